// ----- rtl/rrpc_pkg.sv -----
// Package for the rectangle-region pointer confine block.
// Holds action codes, config indices, state enum and a saturation function; no dependencies.
package rrpc_pkg;

    localparam int unsigned CoordW = 15;
    localparam int unsigned PosW   = 32;
    localparam int unsigned WideW  = 42;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_CONFINE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_ORIGIN_X = 2'd1,
        CFG_ORIGIN_Y = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIST_A,
        ST_DIST_B,
        ST_DIST_C,
        ST_DIST_D,
        ST_PICK,
        ST_OUT
    } t_state;

    // Sign-preserving clamp of a wide value into 32 bits.
    function automatic logic [PosW-1:0] sat32(input logic signed [WideW-1:0] v);
        logic signed [WideW-1:0] hi;
        logic signed [WideW-1:0] lo;
        begin
            hi = WideW'(signed'(33'sh0_7fff_ffff));
            lo = -hi - WideW'(1);
            if (v > hi) begin
                sat32 = 32'h7fff_ffff;
            end else if (v < lo) begin
                sat32 = 32'h8000_0000;
            end else begin
                sat32 = v[PosW-1:0];
            end
        end
    endfunction

endpackage

// ----- rtl/rect_region_pointer_confine.sv -----
// Top level of the rectangle-region pointer confine block.
// Depends on rrpc_pkg; holds the box memory and the scan sequencer.
//
// Usage:
//  Input channel i_valid/o_stall carries one item: clear, append or confine.
//  Output channel o_valid/i_stall returns exactly one result per item.
//  Configuration writes (enable, origin x, origin y) go through i_cfg_we,
//  i_cfg_idx, i_cfg_data while the block is idle.
//  Clear, append, action three and moves with confinement off load the
//  result register at the input transfer edge: valid on the next cycle.
//  A confine move runs four scans of the box memory, one box per cycle
//  through a single registered read port; a scan ends early once the
//  interval holding the start is closed.
//  One item is processed at a time; o_stall stays high while busy or
//  while a result waits in the output register, so the next item can
//  transfer in the cycle after the result transfers.
//  Reset empties the table (count to zero), clears enable and origins.
//  A stalled result holds its value until transferred.
module rect_region_pointer_confine #(
    parameter int unsigned MAX_BOXES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_action,
    input  logic [14:0]         i_box_x1,
    input  logic [14:0]         i_box_y1,
    input  logic [14:0]         i_box_x2,
    input  logic [14:0]         i_box_y2,
    input  logic signed [31:0]  i_start_x,
    input  logic signed [31:0]  i_start_y,
    input  logic signed [31:0]  i_target_x,
    input  logic signed [31:0]  i_target_y,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic                o_status,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data
);

    localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int unsigned CW = $clog2(MAX_BOXES + 1);
    localparam int unsigned W  = rrpc_pkg::WideW;

    // configuration
    logic               r_enable;
    logic signed [23:0] r_org_x;
    logic signed [23:0] r_org_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_org_x  <= '0;
            r_org_y  <= '0;
        end else if (i_cfg_we) begin
            case (rrpc_pkg::t_cfg_idx'(i_cfg_idx))
                rrpc_pkg::CFG_ENABLE:   r_enable <= i_cfg_data[0];
                rrpc_pkg::CFG_ORIGIN_X: r_org_x  <= i_cfg_data;
                rrpc_pkg::CFG_ORIGIN_Y: r_org_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // box memory: {x1, y1, x2, y2}
    logic [59:0]   mem [MAX_BOXES];
    logic [59:0]   r_rd;
    logic [AW-1:0] raddr;
    logic          mem_we;
    logic [AW-1:0] waddr;

    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= {i_box_x1, i_box_y1, i_box_x2, i_box_y2};
        end
        r_rd <= mem[raddr];
    end

    // sequencer state
    rrpc_pkg::t_state r_state, n_state;
    logic [1:0]          r_pass;
    logic [CW-1:0]       r_idx;
    logic                r_rdv;
    logic                r_done;
    logic signed [W-1:0] r_sx, r_sy, r_tx, r_ty, r_ox, r_oy;
    logic signed [W-1:0] r_lo, r_hi, r_res;
    logic signed [W-1:0] r_ax, r_ay, r_qx, r_qy;
    logic signed [W-1:0] r_dx, r_dy;
    logic [33:0]         r_pxh, r_pxm, r_pxl, r_pyh, r_pym, r_pyl;
    logic [67:0]         r_sqx, r_sqy;
    logic [68:0]         r_da;
    logic                r_ov;
    logic [31:0]         r_ox_out, r_oy_out;
    logic                r_ost;

    // read the entry the scan index points at
    assign raddr = r_idx[AW-1:0];

    logic accept, out_xfer;
    assign accept   = i_valid && !o_stall;
    assign out_xfer = r_ov && !i_stall;
    assign o_stall  = (r_state != rrpc_pkg::ST_IDLE) || r_ov;

    assign o_valid  = r_ov;
    assign o_out_x  = r_ox_out;
    assign o_out_y  = r_oy_out;
    assign o_status = r_ost;

    assign mem_we = accept && (rrpc_pkg::t_action'(i_action) == rrpc_pkg::ACT_APPEND)
                    && (r_count < CW'(MAX_BOXES));
    assign waddr  = r_count[AW-1:0];

    // per-pass operands: pass0 x(ax), 1 y(ay), 2 y(qy), 3 x(qx)
    logic                horiz;
    logic signed [W-1:0] p_start, p_other, p_target;
    always_comb begin
        horiz    = (r_pass == 2'd0) || (r_pass == 2'd3);
        p_start  = horiz ? r_sx : r_sy;
        p_target = horiz ? r_tx : r_ty;
        case (r_pass)
            2'd0:    p_other = r_sy;
            2'd1:    p_other = r_ax;
            2'd2:    p_other = r_sx;
            default: p_other = r_qy;
        endcase
    end

    // one merging step on the registered box
    logic signed [W-1:0] pl, ph, ea, eb, n_lo, n_hi;
    logic                hit, brk, in_iv;
    always_comb begin
        pl = W'(horiz ? r_rd[44:30] : r_rd[59:45]) <<< 8;
        ph = W'(horiz ? r_rd[14:0]  : r_rd[29:15]) <<< 8;
        ea = W'(horiz ? r_rd[59:45] : r_rd[44:30]) <<< 8;
        eb = (W'(horiz ? r_rd[29:15] : r_rd[14:0]) <<< 8) - W'(1);
        hit   = !(p_other < pl || p_other >= ph);
        in_iv = (p_start >= r_lo) && (p_start <= r_hi);
        brk   = 1'b0;
        n_lo  = r_lo;
        n_hi  = r_hi;
        if (hit) begin
            if (r_hi >= r_lo && ea > r_hi + W'(1)) begin
                if (in_iv) begin
                    brk = 1'b1;
                end else begin
                    n_lo = ea;
                end
            end else if (r_hi < r_lo) begin
                n_lo = ea;
            end
            if (!brk && eb > n_hi) n_hi = eb;
        end
    end

    logic signed [W-1:0] clamped;
    always_comb begin
        clamped = p_target;
        if (clamped > r_hi) clamped = r_hi;
        if (clamped < r_lo) clamped = r_lo;
    end

    // magnitudes stay below 2^33; square them from 17-bit halves
    logic [W-1:0] mx, my;
    assign mx = r_dx[W-1] ? W'(-r_dx) : W'(r_dx);
    assign my = r_dy[W-1] ? W'(-r_dy) : W'(r_dy);

    logic [16:0] xh, xl, yh, yl;
    assign xh = mx[33:17];
    assign xl = mx[16:0];
    assign yh = my[33:17];
    assign yl = my[16:0];

    // recombine registered partial products
    logic [67:0] sq_x, sq_y;
    assign sq_x = (68'(r_pxh) << 34) + (68'(r_pxm) << 18) + 68'(r_pxl);
    assign sq_y = (68'(r_pyh) << 34) + (68'(r_pym) << 18) + 68'(r_pyl);

    logic [68:0] sum_now;
    assign sum_now = 69'(r_sqx) + 69'(r_sqy);

    always_comb begin
        n_state = r_state;
        case (r_state)
            rrpc_pkg::ST_IDLE:
                if (accept && rrpc_pkg::t_action'(i_action) == rrpc_pkg::ACT_CONFINE
                    && r_enable) n_state = rrpc_pkg::ST_SCAN_REQ;
            rrpc_pkg::ST_SCAN_REQ: n_state = rrpc_pkg::ST_SCAN;
            rrpc_pkg::ST_SCAN:
                if (r_done) n_state = rrpc_pkg::ST_SCAN_END;
            rrpc_pkg::ST_SCAN_END:
                n_state = (r_pass == 2'd3) ? rrpc_pkg::ST_DIST_A : rrpc_pkg::ST_SCAN_REQ;
            rrpc_pkg::ST_DIST_A: n_state = rrpc_pkg::ST_DIST_B;
            rrpc_pkg::ST_DIST_B: n_state = rrpc_pkg::ST_DIST_C;
            rrpc_pkg::ST_DIST_C: n_state = rrpc_pkg::ST_DIST_D;
            rrpc_pkg::ST_DIST_D: n_state = rrpc_pkg::ST_PICK;
            rrpc_pkg::ST_PICK:   n_state = rrpc_pkg::ST_OUT;
            rrpc_pkg::ST_OUT:    n_state = rrpc_pkg::ST_IDLE;
            default:             n_state = rrpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrpc_pkg::ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_rdv   <= 1'b0;
            r_done  <= 1'b0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            if (out_xfer) r_ov <= 1'b0;
            case (r_state)
                rrpc_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_pass <= '0;
                        case (rrpc_pkg::t_action'(i_action))
                            rrpc_pkg::ACT_CLEAR: begin
                                r_count <= '0;
                                r_ov <= 1'b1; r_ost <= 1'b0;
                                r_ox_out <= '0; r_oy_out <= '0;
                            end
                            rrpc_pkg::ACT_APPEND: begin
                                if (r_count < CW'(MAX_BOXES)) begin
                                    r_count <= r_count + CW'(1);
                                    r_ost <= 1'b0;
                                end else begin
                                    r_ost <= 1'b1;
                                end
                                r_ov <= 1'b1;
                                r_ox_out <= '0; r_oy_out <= '0;
                            end
                            rrpc_pkg::ACT_CONFINE: begin
                                if (!r_enable) begin
                                    r_ov <= 1'b1; r_ost <= 1'b0;
                                    r_ox_out <= i_target_x; r_oy_out <= i_target_y;
                                end
                                r_ox <= W'(r_org_x) <<< 8;
                                r_oy <= W'(r_org_y) <<< 8;
                                r_sx <= W'(i_start_x) - (W'(r_org_x) <<< 8);
                                r_sy <= W'(i_start_y) - (W'(r_org_y) <<< 8);
                                r_tx <= W'(i_target_x) - (W'(r_org_x) <<< 8);
                                r_ty <= W'(i_target_y) - (W'(r_org_y) <<< 8);
                            end
                            default: begin
                                r_ov <= 1'b1; r_ost <= 1'b0;
                                r_ox_out <= '0; r_oy_out <= '0;
                            end
                        endcase
                    end
                end
                rrpc_pkg::ST_SCAN_REQ: begin
                    // start a pass: empty interval, index at the first box
                    r_lo    <= '0;
                    r_hi    <= -W'(1);
                    r_idx   <= '0;
                    r_rdv   <= 1'b0;
                    r_done  <= 1'b0;
                    r_res   <= '0;
                end
                rrpc_pkg::ST_SCAN: begin
                    // issue read for r_idx, consume data of previous index
                    if (!r_done) begin
                        if (r_rdv) begin
                            r_lo <= n_lo;
                            r_hi <= n_hi;
                            if (brk) begin
                                r_done <= 1'b1;
                                r_res  <= clamped;
                            end
                        end
                        if (!(r_rdv && brk)) begin
                            if (r_idx < r_count) begin
                                r_idx   <= r_idx + CW'(1);
                                r_rdv   <= 1'b1;
                            end else begin
                                r_rdv  <= 1'b0;
                                r_done <= 1'b1;
                                r_res  <= (r_rdv ? ((p_start >= n_lo && p_start <= n_hi)
                                           ? ((p_target > n_hi) ? n_hi :
                                              (p_target < n_lo) ? n_lo : p_target)
                                           : p_start)
                                           : (in_iv ? clamped : p_start));
                            end
                        end
                    end
                end
                rrpc_pkg::ST_SCAN_END: begin
                    case (r_pass)
                        2'd0:    r_ax <= r_res;
                        2'd1:    r_ay <= r_res;
                        2'd2:    r_qy <= r_res;
                        default: r_qx <= r_res;
                    endcase
                    r_pass <= r_pass + 2'd1;
                    r_dx   <= r_tx - r_ax;
                    r_dy   <= r_ty - r_ay;
                end
                rrpc_pkg::ST_DIST_A: begin
                    r_dx <= r_tx - r_ax;
                    r_dy <= r_ty - r_ay;
                end
                rrpc_pkg::ST_DIST_B: begin
                    // partial products of the x-first offset
                    r_pxh <= 34'(xh) * 34'(xh);
                    r_pxm <= 34'(xh) * 34'(xl);
                    r_pxl <= 34'(xl) * 34'(xl);
                    r_pyh <= 34'(yh) * 34'(yh);
                    r_pym <= 34'(yh) * 34'(yl);
                    r_pyl <= 34'(yl) * 34'(yl);
                    r_dx  <= r_tx - r_qx;
                    r_dy  <= r_ty - r_qy;
                end
                rrpc_pkg::ST_DIST_C: begin
                    // squares of x-first, partial products of y-first
                    r_sqx <= sq_x;
                    r_sqy <= sq_y;
                    r_pxh <= 34'(xh) * 34'(xh);
                    r_pxm <= 34'(xh) * 34'(xl);
                    r_pxl <= 34'(xl) * 34'(xl);
                    r_pyh <= 34'(yh) * 34'(yh);
                    r_pym <= 34'(yh) * 34'(yl);
                    r_pyl <= 34'(yl) * 34'(yl);
                end
                rrpc_pkg::ST_DIST_D: begin
                    r_da  <= sum_now;
                    r_sqx <= sq_x;
                    r_sqy <= sq_y;
                end
                rrpc_pkg::ST_PICK: begin
                    // keep y-first only when strictly nearer
                    if (sum_now < r_da) begin
                        r_ox_out <= rrpc_pkg::sat32(r_ox + r_qx);
                        r_oy_out <= rrpc_pkg::sat32(r_oy + r_qy);
                    end else begin
                        r_ox_out <= rrpc_pkg::sat32(r_ox + r_ax);
                        r_oy_out <= rrpc_pkg::sat32(r_oy + r_ay);
                    end
                    r_ost <= 1'b0;
                end
                rrpc_pkg::ST_OUT: r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/rrpc_checker.sv -----
// Port-level checker for rect_region_pointer_confine, with its bind.
// Depends only on the top level's ports.
module rrpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_x,
    input logic        o_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x))
        else $error("result changed under stall");

    // no intake while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("intake while result pending");

    // an item transfer is followed by busy
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after transfer");

    // status only flags on dropped appends, with zero x position
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_out_x == 32'd0)
        else $error("status with position");

endmodule

bind rect_region_pointer_confine rrpc_checker u_rrpc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_out_x  (o_out_x),
    .o_status (o_status)
);
